[sv/hteb_pkg.sv]
// Shared types and constants of the hit time-window event builder.
package hteb_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 40;
  localparam int unsigned DIFF_W     = TIME_W + 1;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned QUAL_W     = 2;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned WIN_W      = 20;
  localparam int unsigned MINH_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CORRUPTED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS      = 2'd2;

  // Configuration reset values
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 20'd5000;
  localparam logic [MINH_W-1:0] MIN_HITS_RESET = 5'd1;

  // Quality codes
  localparam logic [QUAL_W-1:0] QUAL_GOOD    = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_CORRUPT = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_UNKNOWN = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_LOAD
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture the input request
    logic wr_join;   // append held hit to the open event
    logic close;     // close the open event
    logic try_open;  // open a new event with the held hit if allowed
    logic rd_start;  // restart the buffer walk at entry zero
    logic out_load;  // move buffer data into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_end;  // held request is an end-of-slot marker
    logic open;      // an event is open
    logic fits;      // held hit falls in the window and the buffer has room
    logic emit_ok;   // open event meets the minimum multiplicity
    logic last;      // current walk entry is the final hit
    logic out_free;  // output register can take a new request
  } status_t;

endpackage

[sv/hteb_ctrl.sv]
// Controller state machine of the hit time-window event builder.
module hteb_ctrl
  import hteb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.open && status_i.emit_ok &&
            (status_i.slot_end || !status_i.fits)) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          state_d = status_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      ST_DECIDE: begin
        if (status_i.slot_end) begin
          if (status_i.open && status_i.emit_ok) begin
            cmd_o.rd_start = 1'b1;
          end else begin
            cmd_o.close = 1'b1;
          end
        end else if (status_i.open && status_i.fits) begin
          cmd_o.wr_join = 1'b1;
        end else if (status_i.open && status_i.emit_ok) begin
          cmd_o.rd_start = 1'b1;
        end else begin
          cmd_o.close    = 1'b1;
          cmd_o.try_open = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o = '0;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.last) begin
            cmd_o.close    = 1'b1;
            cmd_o.try_open = !status_i.slot_end;
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[sv/hteb_datapath.sv]
// Datapath of the hit time-window event builder: config, event state, hit buffer, output.
module hteb_datapath
  import hteb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input request
  input  logic                     slot_end_i,
  input  logic signed [TIME_W-1:0] hit_time_i,
  input  logic [TAG_W-1:0]         hit_tag_i,
  input  logic [QUAL_W-1:0]        hit_quality_i,
  // output request
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic signed [TIME_W-1:0] out_time_o,
  output logic [TAG_W-1:0]         out_tag_o,
  output logic [QUAL_W-1:0]        event_quality_o,
  output logic [SIZE_W-1:0]        event_size_o,
  output logic                     last_of_event_o,
  // controller link
  input  cmd_t                     cmd_i,
  output status_t                  status_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned CMP_W = (CNT_W > MINH_W) ? CNT_W : MINH_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

  // Configuration registers
  logic               use_corrupted_q;
  logic [WIN_W-1:0]   window_q;
  logic [MINH_W-1:0]  min_hits_q;

  // Event state
  logic               open_q, open_d;
  logic [TIME_W-1:0]  first_time_q, first_time_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [QUAL_W-1:0]  qual_q, qual_d;

  // Held request
  logic               hold_end_q;
  logic [TIME_W-1:0]  hold_time_q;
  logic [TAG_W-1:0]   hold_tag_q;
  logic [QUAL_W-1:0]  hold_qual_q;
  logic signed [DIFF_W-1:0] diff_q;

  // Buffer
  logic [TIME_W-1:0]  time_mem [BUFFER_DEPTH];
  logic [TAG_W-1:0]   tag_mem  [BUFFER_DEPTH];
  logic [TIME_W-1:0]  rd_time_q;
  logic [TAG_W-1:0]   rd_tag_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;

  // Output register
  logic               out_valid_q;
  logic [TIME_W-1:0]  out_time_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [QUAL_W-1:0]  out_qual_q;
  logic [SIZE_W-1:0]  out_size_q;
  logic               out_last_q;

  // Decision terms
  logic signed [DIFF_W-1:0] win_s;
  logic signed [DIFF_W-1:0] neg_win_s;
  logic               in_window;
  logic               hold_corrupt;
  logic               open_now;
  logic [QUAL_W-1:0]  open_qual;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   minh_ext;
  logic [CNT_W-1:0]   rd_next;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_corrupted_q <= 1'b0;
      window_q        <= WINDOW_RESET;
      min_hits_q      <= MIN_HITS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_USE_CORRUPTED: use_corrupted_q <= cfg_data_i[0];
        CFG_WINDOW_PS:     window_q        <= cfg_data_i[WIN_W-1:0];
        CFG_MIN_HITS:      min_hits_q      <= cfg_data_i[MINH_W-1:0];
        default:           ;
      endcase
    end
  end

  // Capture request and its time offset to the event's first hit
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hold_end_q  <= slot_end_i;
      hold_time_q <= hit_time_i;
      hold_tag_q  <= hit_tag_i;
      hold_qual_q <= hit_quality_i;
      diff_q      <= $signed({hit_time_i[TIME_W-1], hit_time_i}) -
                     $signed({first_time_q[TIME_W-1], first_time_q});
    end
  end

  // Window test: -window < diff < window
  assign win_s     = $signed({{(DIFF_W-WIN_W){1'b0}}, window_q});
  assign neg_win_s = -win_s;
  assign in_window = (diff_q < win_s) && (diff_q > neg_win_s);

  assign hold_corrupt = (hold_qual_q == QUAL_CORRUPT);
  assign open_now     = cmd_i.try_open && !(hold_corrupt && !use_corrupted_q);
  assign open_qual    = (hold_qual_q == QUAL_GOOD) ? QUAL_GOOD :
                        (hold_corrupt ? QUAL_CORRUPT : QUAL_UNKNOWN);

  // Update event state: close first, then join or open
  always_comb begin
    open_d       = open_q;
    first_time_d = first_time_q;
    count_d      = count_q;
    qual_d       = qual_q;
    if (cmd_i.close) begin
      open_d  = 1'b0;
      count_d = '0;
      qual_d  = QUAL_UNKNOWN;
    end
    if (cmd_i.wr_join) begin
      count_d = count_q + CNT_W'(1);
      if (hold_corrupt) begin
        qual_d = QUAL_CORRUPT;
      end
    end
    if (open_now) begin
      open_d       = 1'b1;
      first_time_d = hold_time_q;
      count_d      = CNT_W'(1);
      qual_d       = open_qual;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      first_time_q <= '0;
      count_q      <= '0;
      qual_q       <= QUAL_UNKNOWN;
    end else begin
      open_q       <= open_d;
      first_time_q <= first_time_d;
      count_q      <= count_d;
      qual_q       <= qual_d;
    end
  end

  // Hit buffer: one write port, registered read at the walk index
  assign mem_we    = cmd_i.wr_join || open_now;
  assign mem_waddr = open_now ? '0 : count_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[mem_waddr] <= hold_time_q;
      tag_mem[mem_waddr]  <= hold_tag_q;
    end
    rd_time_q <= time_mem[rd_idx_q];
    rd_tag_q  <= tag_mem[rd_idx_q];
  end

  // Advance walk index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_start) begin
      rd_idx_q <= '0;
    end else if (cmd_i.out_load) begin
      rd_idx_q <= rd_idx_q + IDX_W'(1);
    end
  end

  assign rd_next  = CNT_W'(rd_idx_q) + CNT_W'(1);
  assign cnt_ext  = CMP_W'(count_q);
  assign minh_ext = CMP_W'(min_hits_q);

  // Output register: load on command, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_time_q <= rd_time_q;
      out_tag_q  <= rd_tag_q;
      out_qual_q <= qual_q;
      out_size_q <= cnt_ext[SIZE_W-1:0];
      out_last_q <= (rd_next == count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_time_o      = out_time_q;
  assign out_tag_o       = out_tag_q;
  assign event_quality_o = out_qual_q;
  assign event_size_o    = out_size_q;
  assign last_of_event_o = out_last_q;

  // Status to controller
  assign status_o.slot_end = hold_end_q;
  assign status_o.open     = open_q;
  assign status_o.fits     = in_window && (count_q < DEPTH_CNT);
  assign status_o.emit_ok  = (cnt_ext >= minh_ext);
  assign status_o.last     = (rd_next == count_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("hit count beyond buffer depth");

  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (count_q != '0))
    else $error("event open flag and hit count disagree");

  a_join_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_join |-> (open_q && count_q < DEPTH_CNT))
    else $error("hit appended without an open event or room");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");
`endif

endmodule

[sv/hit_time_window_event_builder.sv]
// Top level of the hit time-window event builder.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   slot_end, hit_time, hit_tag, hit_quality
//  out      output     out_valid_o / out_stall_i time, tag, event quality, size, last
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A hit that joins, opens or is dropped is accepted in ST_IDLE and then decided in ST_DECIDE.
// Closing an emitted event walks the hit buffer through its single registered read port:
// each hit is read (ST_READ), then loaded into the output register (ST_LOAD) when free.
// Reset returns control and configuration to their reset values at once; there is no clearing pass.
// in_stall_o is high after accept until the request is fully handled.
module hit_time_window_event_builder
  import hteb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input requests
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     slot_end_i,
  input  logic signed [TIME_W-1:0] hit_time_i,
  input  logic [TAG_W-1:0]         hit_tag_i,
  input  logic [QUAL_W-1:0]        hit_quality_i,
  // output requests
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TIME_W-1:0] out_time_o,
  output logic [TAG_W-1:0]         out_tag_o,
  output logic [QUAL_W-1:0]        event_quality_o,
  output logic [SIZE_W-1:0]        event_size_o,
  output logic                     last_of_event_o
);

  cmd_t    cmd;
  status_t status;

  // Sequence the work on each request
  hteb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold event state, buffer and output register
  hteb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .slot_end_i      (slot_end_i),
    .hit_time_i      (hit_time_i),
    .hit_tag_i       (hit_tag_i),
    .hit_quality_i   (hit_quality_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_time_o      (out_time_o),
    .out_tag_o       (out_tag_o),
    .event_quality_o (event_quality_o),
    .event_size_o    (event_size_o),
    .last_of_event_o (last_of_event_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule
